// File: rtl/core/sscq_pkg.sv
// types and constants for the sorted state change queue
// no dependencies
package sscq_pkg;

    typedef struct packed {
        logic        kind;
        logic [31:0] sort_key_a;
        logic [31:0] sort_key_b;
        logic [31:0] sort_key_c;
        logic [31:0] effect_id;
        logic [7:0]  pass_number;
        logic [7:0]  bone_count;
        logic [7:0]  detail_level;
        logic [39:0] model_id;
        logic [31:0] model_param_a;
        logic [31:0] model_param_b;
        logic [31:0] surface_id;
    } in_item_t;

    typedef struct packed {
        logic [5:0] entry_slot;
        logic       flag_effect;
        logic       flag_pass;
        logic       flag_param;
        logic       flag_lod;
        logic       flag_model;
        logic       flag_param_a;
        logic       flag_param_b;
        logic       flag_surface;
        logic       last;
    } out_item_t;

    // attributes compared between neighbouring entries
    typedef struct packed {
        logic [31:0] effect_id;
        logic [23:0] pass_bone_lod;
        logic [39:0] model_id;
        logic [31:0] model_param_a;
        logic [31:0] model_param_b;
        logic [31:0] surface_id;
    } attr_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } keys_t;

    localparam logic KIND_PUSH  = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    function automatic logic goes_after(input keys_t x, input keys_t y);
        logic r;
        if (x.a != y.a)
            r = x.a > y.a;
        else if (x.b != y.b)
            r = x.b > y.b;
        else
            r = x.c > y.c;
        return r;
    endfunction

    function automatic out_item_t change_flags(input attr_t p, input attr_t c);
        out_item_t o;
        o = '0;
        if (p.effect_id != c.effect_id)
        begin
            o.flag_effect = 1'b1;
            o.flag_pass   = 1'b1;
            o.flag_param  = 1'b1;
        end
        else if (p.pass_bone_lod[23:16] != c.pass_bone_lod[23:16])
        begin
            o.flag_pass  = 1'b1;
            o.flag_param = 1'b1;
        end
        else
        begin
            o.flag_param = p.pass_bone_lod[15:8] != c.pass_bone_lod[15:8];
            o.flag_lod   = p.pass_bone_lod[7:0] != c.pass_bone_lod[7:0];
        end
        if (p.model_id != c.model_id)
        begin
            o.flag_model   = 1'b1;
            o.flag_param_a = 1'b1;
            o.flag_param_b = 1'b1;
        end
        else
        begin
            o.flag_param_a = p.model_param_a != c.model_param_a;
            o.flag_param_b = p.model_param_b != c.model_param_b;
        end
        o.flag_surface = p.surface_id != c.surface_id;
        return o;
    endfunction

endpackage

// File: rtl/core/sorted_state_change_queue_unit.sv
// Each push is taken and then written to the memories in the next cycle, so no new
// push is accepted until the last one is stored. A flush (explicit, or a push finding
// MAX_ENTRIES-1 entries) first writes the identity order. It then runs a stable
// insertion sort over the order memory: for each element it reads the order entry,
// its keys and the previous keys and compares them; each shift reads the next keys
// and compares again; a move to the front adds a place step. It then emits one
// result per entry (order read, attribute read, compare), waiting while the output
// stalls. The input stalls from acceptance of a flush until the last result is
// registered on the output. A push that forced the flush is stored afterwards.
// depends on sscq_pkg
module sorted_state_change_queue_unit
    import sscq_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INIT  = 4'd1;
    localparam logic [3:0] ST_OUTER = 4'd2;
    localparam logic [3:0] ST_RDCUR = 4'd3;
    localparam logic [3:0] ST_RDPRV = 4'd4;
    localparam logic [3:0] ST_CMP   = 4'd5;
    localparam logic [3:0] ST_EMRD  = 4'd6;
    localparam logic [3:0] ST_EMCUR = 4'd7;
    localparam logic [3:0] ST_EMOUT = 4'd8;
    localparam logic [3:0] ST_STORE = 4'd9;
    localparam logic [3:0] ST_RDNXT = 4'd10;
    localparam logic [3:0] ST_PLACE = 4'd11;

    keys_t          key_mem  [MAX_ENTRIES];
    attr_t          attr_mem [MAX_ENTRIES];
    logic [AW-1:0]  ord_mem  [MAX_ENTRIES];

    logic [3:0]     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  i_reg, i_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [AW-1:0]  cur_reg, cur_next;
    keys_t          cur_key_reg, cur_key_next;
    logic           pend_reg, pend_next;
    in_item_t       pend_item_reg, pend_item_next;
    attr_t          prev_attr_reg, prev_attr_next;
    logic           out_valid_reg, out_valid_next;
    out_item_t      out_reg, out_next;

    // memory ports
    logic           kw_en;
    logic [AW-1:0]  kw_addr;
    keys_t          kw_data;
    logic           ow_en;
    logic [AW-1:0]  ow_addr;
    logic [AW-1:0]  ow_data;
    logic [AW-1:0]  or_addr;
    logic [AW-1:0]  or_q;
    logic [AW-1:0]  kr_addr;
    keys_t          kr_q;
    logic [AW-1:0]  ar_addr;
    attr_t          ar_q;
    logic [AW-1:0]  prv_slot_reg, prv_slot_next;

    attr_t          in_attr;
    logic           accept;

    assign in_attr.effect_id     = pend_item_reg.effect_id;
    assign in_attr.pass_bone_lod = {pend_item_reg.pass_number, pend_item_reg.bone_count,
                                    pend_item_reg.detail_level};
    assign in_attr.model_id      = pend_item_reg.model_id;
    assign in_attr.model_param_a = pend_item_reg.model_param_a;
    assign in_attr.model_param_b = pend_item_reg.model_param_b;
    assign in_attr.surface_id    = pend_item_reg.surface_id;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (kw_en)
            key_mem[kw_addr] <= kw_data;
        if (state_reg == ST_STORE)
            attr_mem[count_reg[AW-1:0]] <= in_attr;
        if (ow_en)
            ord_mem[ow_addr] <= ow_data;
        kr_q <= key_mem[kr_addr];
        ar_q <= attr_mem[ar_addr];
        or_q <= ord_mem[or_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        cur_reg       <= cur_next;
        cur_key_reg   <= cur_key_next;
        pend_item_reg <= pend_item_next;
        prev_attr_reg <= prev_attr_next;
        out_reg       <= out_next;
        prv_slot_reg  <= prv_slot_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cur_next       = cur_reg;
        cur_key_next   = cur_key_reg;
        pend_next      = pend_reg;
        pend_item_next = pend_item_reg;
        prev_attr_next = prev_attr_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        prv_slot_next  = prv_slot_reg;
        kw_en   = 1'b0;
        kw_addr = count_reg[AW-1:0];
        kw_data = '{a: pend_item_reg.sort_key_a, b: pend_item_reg.sort_key_b,
                    c: pend_item_reg.sort_key_c};
        ow_en   = 1'b0;
        ow_addr = i_reg[AW-1:0];
        ow_data = i_reg[AW-1:0];
        or_addr = j_reg[AW-1:0];
        kr_addr = cur_reg;
        ar_addr = cur_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_item_next = in_data;
                    pend_next      = (in_data.kind == KIND_PUSH);
                    i_next         = '0;
                    if (in_data.kind == KIND_FLUSH
                        || count_reg + 1'b1 >= CW'(MAX_ENTRIES))
                        state_next = ST_INIT;
                    else
                        state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                kw_en      = 1'b1;
                count_next = count_reg + 1'b1;
                pend_next  = 1'b0;
                state_next = ST_IDLE;
            end
            ST_INIT:
            begin
                // identity order
                if (i_reg < count_reg)
                begin
                    ow_en  = 1'b1;
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    i_next     = CW'(1);
                    state_next = ST_OUTER;
                end
            end
            ST_OUTER:
            begin
                if (i_reg < count_reg)
                begin
                    j_next     = i_reg;
                    or_addr    = i_reg[AW-1:0];
                    state_next = ST_RDCUR;
                end
                else
                begin
                    i_next     = '0;
                    or_addr    = '0;
                    state_next = ST_EMRD;
                    if (count_reg == '0)
                        state_next = pend_reg ? ST_STORE : ST_IDLE;
                end
            end
            ST_RDCUR:
            begin
                // or_q holds the order entry at i; fetch its keys
                cur_next   = or_q;
                kr_addr    = or_q;
                or_addr    = j_reg[AW-1:0] - 1'b1;
                state_next = ST_RDPRV;
            end
            ST_RDPRV:
            begin
                cur_key_next  = kr_q;
                prv_slot_next = or_q;
                kr_addr       = or_q;
                state_next    = ST_CMP;
            end
            ST_RDNXT:
            begin
                prv_slot_next = or_q;
                kr_addr       = or_q;
                state_next    = ST_CMP;
            end
            ST_CMP:
            begin
                if (goes_after(kr_q, cur_key_reg))
                begin
                    ow_en   = 1'b1;
                    ow_addr = j_reg[AW-1:0];
                    ow_data = prv_slot_reg;
                    j_next  = j_reg - 1'b1;
                    if (j_reg == CW'(1))
                        state_next = ST_PLACE;
                    else
                    begin
                        or_addr    = AW'(j_reg - CW'(2));
                        state_next = ST_RDNXT;
                    end
                end
                else
                begin
                    ow_en      = 1'b1;
                    ow_addr    = j_reg[AW-1:0];
                    ow_data    = cur_reg;
                    i_next     = i_reg + 1'b1;
                    state_next = ST_OUTER;
                end
            end
            ST_PLACE:
            begin
                // cur goes to the front
                ow_en      = 1'b1;
                ow_addr    = j_reg[AW-1:0];
                ow_data    = cur_reg;
                i_next     = i_reg + 1'b1;
                state_next = ST_OUTER;
            end
            ST_EMRD:
            begin
                or_addr    = i_reg[AW-1:0];
                state_next = ST_EMCUR;
            end
            ST_EMCUR:
            begin
                cur_next   = or_q;
                ar_addr    = or_q;
                state_next = ST_EMOUT;
            end
            ST_EMOUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    if (i_reg == '0)
                        out_next = '1;
                    else
                        out_next = change_flags(prev_attr_reg, ar_q);
                    out_next.entry_slot = 6'(cur_reg);
                    out_next.last       = (i_reg + 1'b1 == count_reg);
                    out_valid_next      = 1'b1;
                    prev_attr_next      = ar_q;
                    i_next              = i_reg + 1'b1;
                    if (i_reg + 1'b1 == count_reg)
                    begin
                        count_next = '0;
                        state_next = pend_reg ? ST_STORE : ST_IDLE;
                    end
                    else
                        state_next = ST_EMRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("held result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("entry count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_STORE |=> count_reg == $past(count_reg) + 1'b1)
        else $error("store did not advance count");

endmodule

// File: verif/tb_sorted_state_change_queue_unit.sv
// testbench for sorted_state_change_queue_unit: directed and random pushes and flushes,
// results predicted by a stable key sort with state-change flags and checked in order
// depends on sscq_pkg and sorted_state_change_queue_unit
module tb_sorted_state_change_queue_unit
    import sscq_pkg::*;
;

    localparam int QUEUE_DEPTH = 64;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int HOLD_LEN = 3000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    in_item_t  stored_entries[$];
    out_item_t expected_results[$];
    int        mismatches = 0;
    int        idle_pct;
    int        stall_pct;
    logic      hold_go;
    logic      hold_seen = 1'b0;
    int        hold_cycles = 0;
    int        quiet_cycles = 0;

    sorted_state_change_queue_unit #(.MAX_ENTRIES(QUEUE_DEPTH)) uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic sorts_after(input in_item_t x, input in_item_t y);
        if (x.sort_key_a != y.sort_key_a)
            return x.sort_key_a > y.sort_key_a;
        if (x.sort_key_b != y.sort_key_b)
            return x.sort_key_b > y.sort_key_b;
        return x.sort_key_c > y.sort_key_c;
    endfunction

    // stable insertion sort of stored entries, then one result per entry
    function automatic void sort_and_emit();
        int        order[QUEUE_DEPTH];
        int        n;
        int        j;
        int        cur;
        in_item_t  p;
        in_item_t  c;
        out_item_t r;
        n = stored_entries.size();
        for (int i = 0; i < n; i++)
            order[i] = i;
        for (int i = 1; i < n; i++)
        begin
            cur = order[i];
            j = i;
            while (j > 0 && sorts_after(stored_entries[order[j-1]], stored_entries[cur]))
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        for (int i = 0; i < n; i++)
        begin
            c = stored_entries[order[i]];
            r = '0;
            r.entry_slot = order[i][5:0];
            if (i == 0)
            begin
                {r.flag_effect, r.flag_pass, r.flag_param, r.flag_lod} = 4'b1111;
                {r.flag_model, r.flag_param_a, r.flag_param_b, r.flag_surface} = 4'b1111;
            end
            else
            begin
                p = stored_entries[order[i-1]];
                if (p.effect_id != c.effect_id)
                    {r.flag_effect, r.flag_pass, r.flag_param} = 3'b111;
                else if (p.pass_number != c.pass_number)
                    {r.flag_pass, r.flag_param} = 2'b11;
                else
                begin
                    r.flag_param = p.bone_count != c.bone_count;
                    r.flag_lod = p.detail_level != c.detail_level;
                end
                if (p.model_id != c.model_id)
                    {r.flag_model, r.flag_param_a, r.flag_param_b} = 3'b111;
                else
                begin
                    r.flag_param_a = p.model_param_a != c.model_param_a;
                    r.flag_param_b = p.model_param_b != c.model_param_b;
                end
                r.flag_surface = p.surface_id != c.surface_id;
            end
            r.last = (i == n - 1);
            expected_results.push_back(r);
        end
        stored_entries.delete();
    endfunction

    function automatic void predict_transfer(input in_item_t it);
        if (it.kind == KIND_FLUSH)
            sort_and_emit();
        else
        begin
            if (stored_entries.size() + 1 >= QUEUE_DEPTH)
                sort_and_emit();
            stored_entries.push_back(it);
        end
    endfunction

    // mostly a few small values so that neighbours often match
    function automatic logic [31:0] pick_word();
        return ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(2));
    endfunction

    function automatic in_item_t random_push();
        in_item_t it;
        it.kind          = KIND_PUSH;
        it.sort_key_a    = pick_word();
        it.sort_key_b    = pick_word();
        it.sort_key_c    = pick_word();
        it.effect_id     = pick_word();
        it.pass_number   = ($urandom_range(1) == 0) ? 8'($urandom) : 8'($urandom_range(1));
        it.bone_count    = ($urandom_range(1) == 0) ? 8'($urandom) : 8'($urandom_range(1));
        it.detail_level  = ($urandom_range(1) == 0) ? 8'($urandom) : 8'($urandom_range(1));
        it.model_id      = ($urandom_range(2) == 0) ? {$urandom, 8'($urandom)}
                                                    : 40'($urandom_range(2));
        it.model_param_a = pick_word();
        it.model_param_b = pick_word();
        it.surface_id    = pick_word();
        return it;
    endfunction

    function automatic in_item_t flush_item();
        in_item_t it;
        it = random_push();
        it.kind = KIND_FLUSH;
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            in_data  <= random_push();
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_transfer(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic test_empty_and_single();
        send_item(flush_item());
        send_item(random_push());
        send_item(flush_item());
    endtask

    task automatic test_field_extremes();
        in_item_t it;
        it = '0;
        send_item(it);
        it = '1;
        it.kind = KIND_PUSH;
        send_item(it);
        it = '0;
        send_item(it);
        send_item(flush_item());
    endtask

    // each flag rule in turn, keys rising so the load order is kept
    task automatic test_flag_rules();
        in_item_t it;
        it = '0;
        send_item(it);
        it.sort_key_c = 1; it.bone_count = 8'h01;            send_item(it);
        it.sort_key_c = 2; it.detail_level = 8'h01;          send_item(it);
        it.sort_key_c = 3; it.pass_number = 8'h01;           send_item(it);
        it.sort_key_c = 4; it.effect_id = 32'h1;             send_item(it);
        it.sort_key_c = 5; it.model_param_a = 32'h1;         send_item(it);
        it.sort_key_c = 6; it.model_param_b = 32'h1;         send_item(it);
        it.sort_key_c = 7; it.model_id[7:0] = 8'h1;          send_item(it);
        it.sort_key_c = 8; it.model_id[39:8] = 32'h1;        send_item(it);
        it.sort_key_c = 9; it.surface_id = 32'h1;            send_item(it);
        it.sort_key_c = 10;                                  send_item(it);
        send_item(flush_item());
    endtask

    // equal keys keep load order; reversed keys invert it
    task automatic test_stable_sort();
        in_item_t it;
        for (int i = 0; i < 6; i++)
        begin
            it = random_push();
            it.sort_key_a = 32'(2 - i / 2);
            it.sort_key_b = 0;
            it.sort_key_c = 0;
            send_item(it);
        end
        send_item(flush_item());
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_item(random_push());
        send_item(flush_item());
    endtask

    task automatic test_random(input int items);
        int sent;
        int run;
        sent = 0;
        while (sent < items)
        begin
            run = ($urandom_range(9) == 0) ? $urandom_range(QUEUE_DEPTH + 4)
                                           : $urandom_range(12);
            for (int i = 0; i < run; i++)
                send_item(random_push());
            send_item(flush_item());
            sent += run + 1;
        end
    endtask

    task automatic test_backpressure();
        hold_go = 1'b1;
        for (int i = 0; i < 20; i++)
            send_item(random_push());
        send_item(flush_item());
        for (int i = 0; i < 5; i++)
            send_item(random_push());
        send_item(flush_item());
        wait_drained();
    endtask

    // long receiver hold counted here once the test asks for it
    always @(posedge clk)
    begin
        if (hold_go && !hold_seen)
        begin
            hold_seen   <= 1'b1;
            hold_cycles <= HOLD_LEN;
            out_stall   <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected transfer: slot %0d", out_data.entry_slot);
                    mismatches++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (out_data.entry_slot !== e.entry_slot)
                    begin
                        $error("entry_slot: expected %0d actual %0d",
                               e.entry_slot, out_data.entry_slot);
                        mismatches++;
                    end
                    if (out_data.flag_effect !== e.flag_effect)
                    begin
                        $error("flag_effect: expected %0b actual %0b",
                               e.flag_effect, out_data.flag_effect);
                        mismatches++;
                    end
                    if (out_data.flag_pass !== e.flag_pass)
                    begin
                        $error("flag_pass: expected %0b actual %0b",
                               e.flag_pass, out_data.flag_pass);
                        mismatches++;
                    end
                    if (out_data.flag_param !== e.flag_param)
                    begin
                        $error("flag_param: expected %0b actual %0b",
                               e.flag_param, out_data.flag_param);
                        mismatches++;
                    end
                    if (out_data.flag_lod !== e.flag_lod)
                    begin
                        $error("flag_lod: expected %0b actual %0b",
                               e.flag_lod, out_data.flag_lod);
                        mismatches++;
                    end
                    if (out_data.flag_model !== e.flag_model)
                    begin
                        $error("flag_model: expected %0b actual %0b",
                               e.flag_model, out_data.flag_model);
                        mismatches++;
                    end
                    if (out_data.flag_param_a !== e.flag_param_a)
                    begin
                        $error("flag_param_a: expected %0b actual %0b",
                               e.flag_param_a, out_data.flag_param_a);
                        mismatches++;
                    end
                    if (out_data.flag_param_b !== e.flag_param_b)
                    begin
                        $error("flag_param_b: expected %0b actual %0b",
                               e.flag_param_b, out_data.flag_param_b);
                        mismatches++;
                    end
                    if (out_data.flag_surface !== e.flag_surface)
                    begin
                        $error("flag_surface: expected %0b actual %0b",
                               e.flag_surface, out_data.flag_surface);
                        mismatches++;
                    end
                    if (out_data.last !== e.last)
                    begin
                        $error("last: expected %0b actual %0b", e.last, out_data.last);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_go      = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_single();
        test_field_extremes();
        test_flag_rules();
        test_stable_sort();
        wait_drained();
        test_full_queue();
        wait_drained();

        test_random(60);
        wait_drained();
        idle_pct = 83;
        test_random(45);
        wait_drained();
        idle_pct = 0;
        stall_pct = 83;
        test_random(45);
        wait_drained();
        idle_pct = 22;
        stall_pct = 22;
        test_random(90);
        test_backpressure();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
